// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared entry and command types and the opcode and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Opcode of an input item.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Width of the occupancy field on the result channel.
  localparam int unsigned OCC_W = 5;

  // One stored pair.
  typedef struct packed {
    logic signed [31:0] val;
    logic [7:0]         prio;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_cmd_t;

endpackage

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain. Entries are held in descending priority with
// earlier items ahead of later ones of equal priority, so the front cell
// always holds the entry to be removed next.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      prev_keep,
  input  entry_t    prev_entry,
  input  entry_t    next_entry,
  output logic      keep,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // A held entry stays put on insert when it ranks at or above the new one.
  assign keep = occupied && (entry_r.prio >= cmd.new_entry.prio);

  // Insert opens a gap at the first cell that does not keep; remove shifts
  // every entry one cell towards the front.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (!keep) begin
        if (prev_keep) begin
          entry_nxt = cmd.new_entry;
        end else begin
          entry_nxt = prev_entry;
        end
      end
    end else if (cmd.rem) begin
      entry_nxt = next_entry;
    end
  end

  // Payload storage, no reset needed.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: hdl/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Stable priority queue core
// Each result item is registered in the cycle after its input item is accepted.
// Throughput: one item per cycle; each item is one step of the cell chain.
// The input stalls only while a finished result waits on a stalled output.
// Reset clears the entry count and the output valid; cell contents are left.
// ----------------------------------------------------------------------------
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [31:0] in_item_value,
  input  logic [7:0]         in_item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_removed_value,
  output logic [1:0]         out_status,
  output logic [OCC_W-1:0]   out_occupancy
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic signed [31:0] removed_r;
  logic signed [31:0] removed_nxt;
  logic [1:0]         status_r;
  logic [1:0]         status_nxt;
  logic               accept;
  logic               full;
  logic               empty;
  cell_cmd_t          cmd;
  logic [DEPTH:0]     keep_chain;
  entry_t             cell_entry [DEPTH];

  // Handshake: a new item enters whenever the output register can take it.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  // Command for the chain; refused items leave the cells untouched.
  always_comb begin
    cmd.ins            = accept && (in_opcode == OP_INSERT) && !full;
    cmd.rem            = accept && (in_opcode == OP_REMOVE) && !empty;
    cmd.new_entry.val  = in_item_value;
    cmd.new_entry.prio = in_item_priority;
  end

  // A virtual cell ahead of the front always keeps its place.
  assign keep_chain[0] = 1'b1;

  // Row of cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    if (i == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (count_r > CW'(i)),
      .prev_keep  (keep_chain[i]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .keep       (keep_chain[i+1]),
      .entry      (cell_entry[i])
    );
  end

  // Count and result for the accepted item.
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      removed_nxt   = '0;
      status_nxt    = ST_OK;
      if (in_opcode == OP_INSERT) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end else begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = cell_entry[0].val;
          count_nxt   = count_r - CW'(1);
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

  // The occupancy shown is the count after the item, low bits only.
  logic [OCC_W-1:0] occ_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      occ_r <= OCC_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = removed_r;
  assign out_status        = status_r;
  assign out_occupancy     = occ_r;

  // The count never exceeds the capacity of the chain.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond capacity");

  // A successful insert grows the count by exactly one.
  a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow count");

  // A successful remove shrinks the count by exactly one.
  a_remove_count : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not shrink count");

  // A stalled result holds the input back and is kept in place.
  a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(status_r))
    else $error("stalled result lost");

  // The entry count, like the chain, never changes on a refused item.
  a_refused_item : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cmd.ins && !cmd.rem) |=> $stable(count_r))
    else $error("refused item changed count");

endmodule
